>>> hdl/sdspi_pkg.sv
// Shared types and constants for the SD card SPI command sequencer.
`timescale 1ns / 1ps

package sdspi_pkg;

  // Largest data block accepted in one transaction
  localparam int BLOCK_BYTES_DEF = 512;

  // Configuration register indexes
  localparam logic [1:0] CFG_READY_TIMEOUT  = 2'd0;
  localparam logic [1:0] CFG_RESPONSE_TRIES = 2'd1;
  localparam logic [1:0] CFG_TOKEN_TIMEOUT  = 2'd2;
  localparam logic [1:0] CFG_BLOCK_ADDR     = 2'd3;

  // Configuration reset values
  localparam logic [15:0] READY_TIMEOUT_RST  = 16'd50000;
  localparam logic [7:0]  RESPONSE_TRIES_RST = 8'd10;
  localparam logic [16:0] TOKEN_TIMEOUT_RST  = 17'd100000;

  // Completion status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_READY   = 3'd1;
  localparam logic [2:0] ST_R1_REJECT   = 3'd2;
  localparam logic [2:0] ST_TOKEN_TMO   = 3'd3;
  localparam logic [2:0] ST_BAD_TOKEN   = 3'd4;

  // Item modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_RX    = 1'b1;

  // Response kinds
  localparam logic [1:0] KIND_R1    = 2'd0;
  localparam logic [1:0] KIND_TRAIL = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;

  // R1 check rules
  localparam logic [1:0] RULE_ANY      = 2'd0;
  localparam logic [1:0] RULE_ZERO     = 2'd1;
  localparam logic [1:0] RULE_ZERO_IDL = 2'd2;

  // Bus byte values
  localparam logic [7:0] BYTE_IDLE  = 8'hFF;
  localparam logic [7:0] BYTE_TOKEN = 8'hFE;
  localparam logic [7:0] CMD_PREFIX = 8'h40;

  // Transaction phases
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_PRE   = 4'd1,
    PH_READY = 4'd2,
    PH_CMD   = 4'd3,
    PH_RESP  = 4'd4,
    PH_TRAIL = 4'd5,
    PH_TOKEN = 4'd6,
    PH_DATA  = 4'd7,
    PH_CRC   = 4'd8,
    PH_FINAL = 4'd9
  } phase_t;

endpackage

>>> hdl/sd_spi_command_sequencer_top.sv
// Byte-level SD card SPI-mode command transaction sequencer.
//
// Usage: a start item (mode 0) latches a command and returns the first
// deselect byte. Every later item (mode 1) carries the byte received in the
// previous exchange and returns the next byte to send with the chip-select
// level, a received data-block byte where one arrived, or, for the item after
// the final deselect byte, the completion status, R1 and trailer word.
// A received-byte item while idle yields no result. A start item while busy
// abandons the running transaction.
// Channels: in_* and out_* use valid/ready; cfg_* writes one register per
// item and is always ready; the user must write configuration only while
// idle; the block itself does not enforce it. Timing: an accepted item waits
// in the input register and its result is registered into the output register
// once the output is free. Throughput: one item per cycle while the output is
// not stalled, set by the single decision stage between the two registers.
// Reset: synchronous active-low; phase goes idle, state and config take defaults.
// Stall: while out_ready is low the result holds and the input register
// still takes one more item; then in_ready drops until the result drains.
`timescale 1ns / 1ps

module sd_spi_command_sequencer_top
  import sdspi_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [5:0]  in_command_index,
  input  logic [31:0] in_argument,
  input  logic [7:0]  in_crc_byte,
  input  logic [1:0]  in_response_kind,
  input  logic [1:0]  in_r1_rule,
  input  logic        in_scale_arg,
  input  logic [9:0]  in_data_length,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_exchange_request,
  output logic [7:0]  out_tx_byte,
  output logic        out_cs_active,
  output logic [7:0]  out_data_byte,
  output logic        out_data_valid,
  output logic        out_data_last,
  output logic        out_done_res,
  output logic [2:0]  out_status,
  output logic [7:0]  out_r1_value,
  output logic [31:0] out_trailer_word,
  // configuration port
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam logic [10:0] BLK_MAX = 11'(BLOCK_BYTES);

  // Configuration registers
  logic [15:0] ready_timeout_r;
  logic [7:0]  response_tries_r;
  logic [16:0] token_timeout_r;
  logic        block_addr_r;

  // Input register
  logic        s1_valid_r;
  logic        s1_mode_r;
  logic [5:0]  s1_cmd_r;
  logic [31:0] s1_arg_r;
  logic [7:0]  s1_crc_r;
  logic [1:0]  s1_kind_r;
  logic [1:0]  s1_rule_r;
  logic        s1_scale_r;
  logic [9:0]  s1_len_r;
  logic [7:0]  s1_rx_r;

  // Transaction state
  phase_t      phase_r, phase_nxt;
  logic [16:0] poll_r, poll_nxt;
  logic [9:0]  bpos_r, bpos_nxt;
  logic [5:0]  hcmd_r, hcmd_nxt;
  logic [31:0] harg_r, harg_nxt;
  logic [7:0]  hcrc_r, hcrc_nxt;
  logic [1:0]  hkind_r, hkind_nxt;
  logic [1:0]  hrule_r, hrule_nxt;
  logic [9:0]  hlen_r, hlen_nxt;
  logic [7:0]  resp_r, resp_nxt;
  logic [31:0] trail_r, trail_nxt;
  logic [2:0]  fstat_r, fstat_nxt;

  // Result register
  logic        out_valid_r, out_valid_nxt;
  logic        xreq_r, xreq_nxt;
  logic [7:0]  tx_r, tx_nxt;
  logic        cs_r, cs_nxt;
  logic [7:0]  dbyte_r, dbyte_nxt;
  logic        dvalid_r, dvalid_nxt;
  logic        dlast_r, dlast_nxt;
  logic        done_r, done_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic [7:0]  r1v_r, r1v_nxt;
  logic [31:0] trw_r, trw_nxt;

  logic        s1_fire;
  logic        has_result;
  logic [9:0]  bpos_inc;
  logic [16:0] poll_inc;
  logic [7:0]  r1_cur;
  logic        r1_ok;
  logic [31:0] arg_scaled;
  logic [9:0]  len_sat;

  // Command byte at a given position of the six-byte frame
  function automatic logic [7:0] cmd_byte(input logic [9:0] pos, input logic [5:0] cmd,
                                          input logic [31:0] arg, input logic [7:0] crc);
    logic [7:0] b;
    case (pos)
      10'd0:   b = CMD_PREFIX | {2'b00, cmd};
      10'd1:   b = arg[31:24];
      10'd2:   b = arg[23:16];
      10'd3:   b = arg[15:8];
      10'd4:   b = arg[7:0];
      default: b = crc;
    endcase
    return b;
  endfunction

  // Handshakes
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_timeout_r  <= READY_TIMEOUT_RST;
      response_tries_r <= RESPONSE_TRIES_RST;
      token_timeout_r  <= TOKEN_TIMEOUT_RST;
      block_addr_r     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_READY_TIMEOUT:  ready_timeout_r  <= cfg_data[15:0];
        CFG_RESPONSE_TRIES: response_tries_r <= cfg_data[7:0];
        CFG_TOKEN_TIMEOUT:  token_timeout_r  <= cfg_data;
        CFG_BLOCK_ADDR:     block_addr_r     <= cfg_data[0];
        default:            block_addr_r     <= block_addr_r;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r  <= in_mode;
      s1_cmd_r   <= in_command_index;
      s1_arg_r   <= in_argument;
      s1_crc_r   <= in_crc_byte;
      s1_kind_r  <= in_response_kind;
      s1_rule_r  <= in_r1_rule;
      s1_scale_r <= in_scale_arg;
      s1_len_r   <= in_data_length;
      s1_rx_r    <= in_rx_byte;
    end
  end

  // Shared decode
  assign bpos_inc   = bpos_r + 10'd1;
  assign poll_inc   = poll_r + 17'd1;
  assign r1_cur     = (phase_r == PH_RESP) ? s1_rx_r : BYTE_IDLE;
  assign arg_scaled = (s1_scale_r && !block_addr_r) ? {s1_arg_r[22:0], 9'd0} : s1_arg_r;
  assign len_sat    = ({1'b0, s1_len_r} > BLK_MAX) ? BLK_MAX[9:0] : s1_len_r;

  always_comb begin
    case (hrule_r)
      RULE_ANY:      r1_ok = 1'b1;
      RULE_ZERO_IDL: r1_ok = (r1_cur == 8'h00) || (r1_cur == 8'h01);
      default:       r1_ok = (r1_cur == 8'h00);
    endcase
  end

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    poll_nxt   = poll_r;
    bpos_nxt   = bpos_r;
    hcmd_nxt   = hcmd_r;
    harg_nxt   = harg_r;
    hcrc_nxt   = hcrc_r;
    hkind_nxt  = hkind_r;
    hrule_nxt  = hrule_r;
    hlen_nxt   = hlen_r;
    resp_nxt   = resp_r;
    trail_nxt  = trail_r;
    fstat_nxt  = fstat_r;
    has_result = 1'b1;
    if (s1_mode_r == MODE_START) begin
      hcmd_nxt  = s1_cmd_r;
      harg_nxt  = arg_scaled;
      hcrc_nxt  = s1_crc_r;
      hkind_nxt = s1_kind_r;
      hrule_nxt = s1_rule_r;
      hlen_nxt  = len_sat;
      poll_nxt  = '0;
      bpos_nxt  = '0;
      resp_nxt  = BYTE_IDLE;
      trail_nxt = '0;
      fstat_nxt = ST_OK;
      phase_nxt = PH_PRE;
    end else begin
      case (phase_r)
        PH_PRE: begin
          if (ready_timeout_r == 16'd0) begin
            fstat_nxt = ST_NOT_READY;
            phase_nxt = PH_FINAL;
          end else begin
            poll_nxt  = 17'd1;
            phase_nxt = PH_READY;
          end
        end
        PH_READY: begin
          if (s1_rx_r == BYTE_IDLE) begin
            bpos_nxt  = '0;
            phase_nxt = PH_CMD;
          end else if (poll_r >= {1'b0, ready_timeout_r}) begin
            fstat_nxt = ST_NOT_READY;
            phase_nxt = PH_FINAL;
          end else begin
            poll_nxt = poll_inc;
          end
        end
        PH_CMD, PH_RESP: begin
          if (phase_r == PH_CMD && bpos_r < 10'd5) begin
            bpos_nxt = bpos_inc;
          end else if (phase_r == PH_CMD && response_tries_r != 8'd0) begin
            poll_nxt  = 17'd1;
            phase_nxt = PH_RESP;
          end else if (phase_r == PH_RESP && !((s1_rx_r[7] == 1'b0) ||
                       (poll_r >= {9'd0, response_tries_r}))) begin
            resp_nxt = s1_rx_r;
            poll_nxt = poll_inc;
          end else begin
            // R1 settled: check it and pick the response tail
            resp_nxt = r1_cur;
            if (!r1_ok) begin
              fstat_nxt = ST_R1_REJECT;
              phase_nxt = PH_FINAL;
            end else if (hkind_r == KIND_TRAIL) begin
              bpos_nxt  = '0;
              phase_nxt = PH_TRAIL;
            end else if (hkind_r == KIND_DATA) begin
              if (token_timeout_r == 17'd0) begin
                fstat_nxt = ST_TOKEN_TMO;
                phase_nxt = PH_FINAL;
              end else begin
                poll_nxt  = 17'd1;
                phase_nxt = PH_TOKEN;
              end
            end else begin
              fstat_nxt = ST_OK;
              phase_nxt = PH_FINAL;
            end
          end
        end
        PH_TRAIL: begin
          trail_nxt = {trail_r[23:0], s1_rx_r};
          bpos_nxt  = bpos_inc;
          if (bpos_inc >= 10'd4) begin
            fstat_nxt = ST_OK;
            phase_nxt = PH_FINAL;
          end
        end
        PH_TOKEN: begin
          if (s1_rx_r == BYTE_IDLE) begin
            if (poll_r >= token_timeout_r) begin
              fstat_nxt = ST_TOKEN_TMO;
              phase_nxt = PH_FINAL;
            end else begin
              poll_nxt = poll_inc;
            end
          end else if (s1_rx_r == BYTE_TOKEN) begin
            bpos_nxt  = '0;
            phase_nxt = (hlen_r == 10'd0) ? PH_CRC : PH_DATA;
          end else begin
            fstat_nxt = ST_BAD_TOKEN;
            phase_nxt = PH_FINAL;
          end
        end
        PH_DATA: begin
          if (bpos_inc >= hlen_r) begin
            bpos_nxt  = '0;
            phase_nxt = PH_CRC;
          end else begin
            bpos_nxt = bpos_inc;
          end
        end
        PH_CRC: begin
          bpos_nxt = bpos_inc;
          if (bpos_inc >= 10'd2) begin
            fstat_nxt = ST_OK;
            phase_nxt = PH_FINAL;
          end
        end
        PH_FINAL: begin
          phase_nxt = PH_IDLE;
        end
        default: begin
          // idle, or a code with no meaning: no result
          phase_nxt  = PH_IDLE;
          has_result = 1'b0;
        end
      endcase
    end
  end

  // Result fields
  always_comb begin
    xreq_nxt   = 1'b0;
    tx_nxt     = '0;
    cs_nxt     = 1'b0;
    dbyte_nxt  = '0;
    dvalid_nxt = 1'b0;
    dlast_nxt  = 1'b0;
    done_nxt   = 1'b0;
    stat_nxt   = '0;
    r1v_nxt    = '0;
    trw_nxt    = '0;
    if (s1_mode_r == MODE_RX && phase_r == PH_FINAL) begin
      done_nxt = 1'b1;
      stat_nxt = fstat_r;
      r1v_nxt  = resp_r;
      trw_nxt  = trail_r;
    end else if (has_result) begin
      xreq_nxt = 1'b1;
      // chip select drops only for the deselect bytes
      cs_nxt   = !(phase_nxt == PH_PRE || phase_nxt == PH_FINAL);
      if (s1_mode_r == MODE_RX && phase_r == PH_READY && s1_rx_r == BYTE_IDLE) begin
        tx_nxt = cmd_byte(10'd0, hcmd_r, harg_r, hcrc_r);
      end else if (s1_mode_r == MODE_RX && phase_r == PH_CMD && bpos_r < 10'd5) begin
        tx_nxt = cmd_byte(bpos_inc, hcmd_r, harg_r, hcrc_r);
      end else begin
        tx_nxt = BYTE_IDLE;
      end
      if (s1_mode_r == MODE_RX && phase_r == PH_DATA) begin
        dvalid_nxt = 1'b1;
        dbyte_nxt  = s1_rx_r;
        dlast_nxt  = (bpos_inc >= hlen_r);
      end
    end
  end

  // Output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = has_result;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      poll_r      <= '0;
      bpos_r      <= '0;
      hcmd_r      <= '0;
      harg_r      <= '0;
      hcrc_r      <= '0;
      hkind_r     <= '0;
      hrule_r     <= '0;
      hlen_r      <= '0;
      resp_r      <= BYTE_IDLE;
      trail_r     <= '0;
      fstat_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        phase_r <= phase_nxt;
        poll_r  <= poll_nxt;
        bpos_r  <= bpos_nxt;
        hcmd_r  <= hcmd_nxt;
        harg_r  <= harg_nxt;
        hcrc_r  <= hcrc_nxt;
        hkind_r <= hkind_nxt;
        hrule_r <= hrule_nxt;
        hlen_r  <= hlen_nxt;
        resp_r  <= resp_nxt;
        trail_r <= trail_nxt;
        fstat_r <= fstat_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      xreq_r   <= xreq_nxt;
      tx_r     <= tx_nxt;
      cs_r     <= cs_nxt;
      dbyte_r  <= dbyte_nxt;
      dvalid_r <= dvalid_nxt;
      dlast_r  <= dlast_nxt;
      done_r   <= done_nxt;
      stat_r   <= stat_nxt;
      r1v_r    <= r1v_nxt;
      trw_r    <= trw_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_exchange_request = xreq_r;
  assign out_tx_byte          = tx_r;
  assign out_cs_active        = cs_r;
  assign out_data_byte        = dbyte_r;
  assign out_data_valid       = dvalid_r;
  assign out_data_last        = dlast_r;
  assign out_done_res         = done_r;
  assign out_status           = stat_r;
  assign out_r1_value         = r1v_r;
  assign out_trailer_word     = trw_r;

endmodule

>>> hdl/sdspi_checker.sv
// Port-level checker for the SD card SPI command sequencer, with its bind.
`timescale 1ns / 1ps

module sdspi_checker
  import sdspi_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_exchange_request,
  input logic        out_cs_active,
  input logic        out_data_valid,
  input logic        out_data_last,
  input logic        out_done_res,
  input logic [2:0]  out_status,
  input logic [7:0]  out_tx_byte
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte) && $stable(out_done_res))
    else $error("stalled result changed");

  // A result is either the next exchange or the completion, never both
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_exchange_request != out_done_res))
    else $error("result is neither or both exchange and completion");

  // A data byte always comes with the next exchange, last only on a data byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data_valid || out_data_last) |->
      out_data_valid && out_exchange_request && out_cs_active)
    else $error("data byte without selected exchange");

  // Status codes stay within the defined set
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |->
      (out_status == ST_OK) || (out_status == ST_NOT_READY) ||
      (out_status == ST_R1_REJECT) || (out_status == ST_TOKEN_TMO) ||
      (out_status == ST_BAD_TOKEN))
    else $error("undefined status code");

  // No result right after reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sd_spi_command_sequencer_top sdspi_checker u_sdspi_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_exchange_request (out_exchange_request),
  .out_cs_active        (out_cs_active),
  .out_data_valid       (out_data_valid),
  .out_data_last        (out_data_last),
  .out_done_res         (out_done_res),
  .out_status           (out_status),
  .out_tx_byte          (out_tx_byte)
);
